FILE: hw/rtl/point_in_triangle_with_margin_defines.svh
// assertion macros shared by the point-in-triangle design
`ifndef POINT_IN_TRIANGLE_WITH_MARGIN_DEFINES_SVH
`define POINT_IN_TRIANGLE_WITH_MARGIN_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PITM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PITM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pitm_pkg.sv
// types, widths and arithmetic helpers for the point-in-triangle pipeline
package pitm_pkg;

  localparam int NumStages = 7;

  localparam int CoordW  = 16;
  localparam int MarginW = 15;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int SumW    = ProdW + 1;
  localparam int StW     = SumW + 1;
  localparam int SqW     = 2 * CoordW;
  localparam int Dist2W  = SqW + 1;
  localparam int Marg2W  = 2 * MarginW;
  localparam int Len2W   = SqW + 1;
  localparam int MagW    = SqW + 1;
  localparam int LoW     = 16;
  localparam int HiW     = MagW - LoW;
  localparam int PhhW    = 2 * HiW;
  localparam int PhlW    = HiW + LoW;
  localparam int PllW    = 2 * LoW;
  localparam int QhW     = Marg2W + HiW;
  localparam int QlW     = Marg2W + LoW;
  localparam int R2W     = 2 * MagW;
  localparam int RhsW    = Marg2W + Len2W;

  localparam logic signed [CoordW-1:0] NormHalf = 16'sd16384;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [StW-1:0]    st_t;

  typedef struct packed {
    coord_t               point_u;
    coord_t               point_v;
    coord_t               vert_a_u;
    coord_t               vert_a_v;
    coord_t               vert_b_u;
    coord_t               vert_b_v;
    coord_t               vert_c_u;
    coord_t               vert_c_v;
    coord_t               normal_part;
    logic [MarginW-1:0]   margin;
  } in_word_t;

  typedef struct packed {
    logic hit;
  } out_word_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic prod_t mul_s(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic logic [SqW-1:0] sq_u(diff_t a);
    prod_t p;
    p = prod_t'(a) * prod_t'(a);
    return p[SqW-1:0];
  endfunction

endpackage

FILE: hw/rtl/pitm_in_if.sv
// query word channel: point, triangle, normal component and margin
interface pitm_in_if
  import pitm_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pitm_out_if.sv
// result word channel: hit flag
interface pitm_out_if
  import pitm_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pitm_edge.sv
// pipelined distance-to-edge-segment test for one triangle edge
module pitm_edge
  import pitm_pkg::*;
(
  input  logic                   clk_i,
  input  logic [NumStages-2:0]   en_i,
  input  coord_t                 point_u_i,
  input  coord_t                 point_v_i,
  input  coord_t                 x_u_i,
  input  coord_t                 x_v_i,
  input  coord_t                 y_u_i,
  input  coord_t                 y_v_i,
  input  logic [Marg2W-1:0]      m2_i,
  output logic                   near_o
);

  // stage 0: edge and offset vectors
  diff_t gu_d, gv_d, hu_d, hv_d;
  diff_t gu_q, gv_q, hu_q, hv_q;
  // stage 1: products
  prod_t pgu_d, pgv_d, plu_d, plv_d, pra_d, prb_d;
  prod_t pgu_q, pgv_q, plu_q, plv_q, pra_q, prb_q;
  // stage 2: length, projection, cross
  logic [Len2W-1:0] len2_d, len2_q;
  sum_t             lam_d, lam_q, r_d, r_q;
  // stage 3: range check and magnitude
  logic             ok3_d, ok3_q;
  logic [MagW-1:0]  rmag_d, rmag_q;
  logic [Len2W-1:0] len3_q;
  sum_t             rneg;
  // stage 4: partial products
  logic             ok4_q;
  logic [PhhW-1:0]  phh_d, phh_q;
  logic [PhlW-1:0]  phl_d, phl_q;
  logic [PllW-1:0]  pll_d, pll_q;
  logic [QhW-1:0]   qh_d, qh_q;
  logic [QlW-1:0]   ql_d, ql_q;
  // stage 5: full squares
  logic             ok5_q;
  logic [R2W-1:0]   r2_d, r2_q;
  logic [RhsW-1:0]  rhs_d, rhs_q;

  always_comb begin
    gu_d = sub_c(y_u_i, x_u_i);
    gv_d = sub_c(y_v_i, x_v_i);
    hu_d = sub_c(point_u_i, x_u_i);
    hv_d = sub_c(point_v_i, x_v_i);
  end

  always_comb begin
    pgu_d = mul_s(gu_q, gu_q);
    pgv_d = mul_s(gv_q, gv_q);
    plu_d = mul_s(hu_q, gu_q);
    plv_d = mul_s(hv_q, gv_q);
    pra_d = mul_s(hu_q, gv_q);
    prb_d = mul_s(hv_q, gu_q);
  end

  always_comb begin
    len2_d = Len2W'(pgu_q) + Len2W'(pgv_q);
    lam_d  = sum_t'(plu_q) + sum_t'(plv_q);
    r_d    = sum_t'(pra_q) - sum_t'(prb_q);
  end

  always_comb begin
    rneg   = -r_q;
    ok3_d  = !lam_q[SumW-1] && (lam_q <= $signed({2'b00, len2_q}));
    rmag_d = r_q[SumW-1] ? rneg[MagW-1:0] : r_q[MagW-1:0];
  end

  always_comb begin
    phh_d = PhhW'(rmag_q[MagW-1:LoW]) * PhhW'(rmag_q[MagW-1:LoW]);
    phl_d = PhlW'(rmag_q[MagW-1:LoW]) * PhlW'(rmag_q[LoW-1:0]);
    pll_d = PllW'(rmag_q[LoW-1:0]) * PllW'(rmag_q[LoW-1:0]);
    qh_d  = QhW'(m2_i) * QhW'(len3_q[Len2W-1:LoW]);
    ql_d  = QlW'(m2_i) * QlW'(len3_q[LoW-1:0]);
  end

  always_comb begin
    r2_d  = (R2W'(phh_q) << (2 * LoW)) + (R2W'(phl_q) << (LoW + 1)) + R2W'(pll_q);
    rhs_d = (RhsW'(qh_q) << LoW) + RhsW'(ql_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      gu_q <= gu_d;
      gv_q <= gv_d;
      hu_q <= hu_d;
      hv_q <= hv_d;
    end
    if (en_i[1]) begin
      pgu_q <= pgu_d;
      pgv_q <= pgv_d;
      plu_q <= plu_d;
      plv_q <= plv_d;
      pra_q <= pra_d;
      prb_q <= prb_d;
    end
    if (en_i[2]) begin
      len2_q <= len2_d;
      lam_q  <= lam_d;
      r_q    <= r_d;
    end
    if (en_i[3]) begin
      ok3_q  <= ok3_d;
      rmag_q <= rmag_d;
      len3_q <= len2_q;
    end
    if (en_i[4]) begin
      ok4_q <= ok3_q;
      phh_q <= phh_d;
      phl_q <= phl_d;
      pll_q <= pll_d;
      qh_q  <= qh_d;
      ql_q  <= ql_d;
    end
    if (en_i[5]) begin
      ok5_q <= ok4_q;
      r2_q  <= r2_d;
      rhs_q <= rhs_d;
    end
  end

  assign near_o = ok5_q && (r2_q <= R2W'(rhs_q));

endmodule

FILE: hw/rtl/point_in_triangle_with_margin.sv
// top level of the point-in-triangle test with vertex and edge margin
// throughput: one word per cycle; each stage holds only while the stage after it is full
// the edge stages build the 66-bit squared-distance products from 17-bit and 16-bit halves
// reset (asynchronous, active low) clears the stage valid bits only; other registers are not reset
`include "point_in_triangle_with_margin_defines.svh"

module point_in_triangle_with_margin
  import pitm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pitm_in_if.sink    in_i,
  pitm_out_if.source out_o
);

  logic [NumStages-1:0] vld_d, vld_q;
  logic [NumStages-1:0] en;
  in_word_t             w;

  // stage 0
  diff_t du_d, dv_d, eu_d, ev_d, fu_d, fv_d, au_d, av_d, bu_d, bv_d;
  diff_t du_q, dv_q, eu_q, ev_q, fu_q, fv_q, au_q, av_q, bu_q, bv_q;
  logic [MarginW-1:0] m_q;
  logic nen0_d, nen0_q;
  // stage 1
  prod_t dra_d, drb_d, sa_d, sb_d, ta_d, tb_d;
  prod_t dra_q, drb_q, sa_q, sb_q, ta_q, tb_q;
  logic [SqW-1:0] qau_d, qav_d, qbu_d, qbv_d, qcu_d, qcv_d;
  logic [SqW-1:0] qau_q, qav_q, qbu_q, qbv_q, qcu_q, qcv_q;
  logic [Marg2W-1:0] m2_1_d, m2_1_q;
  logic nen1_q;
  // stage 2
  sum_t det_d, det_q, s_d, s_q, t_d, t_q;
  logic [Dist2W-1:0] da_d, da_q, db_d, db_q, dc_d, dc_q;
  logic [Marg2W-1:0] m2_2_q;
  logic nen2_q;
  // stage 3
  st_t  st_d, st_q;
  sum_t det3_q;
  logic snn_d, snn_q, snp_d, snp_q, tnn_d, tnn_q, tnp_d, tnp_q;
  logic vert_d, vert_q;
  logic [Marg2W-1:0] m2_3_q;
  logic nen3_q;
  // stage 4
  logic near4_d, near4_q, nen4_q;
  // stage 5
  logic near5_q, nen5_q;
  // stage 6
  logic hit_d, hit_q;

  logic ea, eb, ec;

  // stage enables: a stage loads when empty or when its word moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_comb begin
    vld_d[0] = in_i.valid;
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign w = in_i.payload;

  always_comb begin
    du_d   = sub_c(w.point_u, w.vert_c_u);
    dv_d   = sub_c(w.point_v, w.vert_c_v);
    eu_d   = sub_c(w.vert_c_u, w.vert_b_u);
    ev_d   = sub_c(w.vert_c_v, w.vert_b_v);
    fu_d   = sub_c(w.vert_a_u, w.vert_c_u);
    fv_d   = sub_c(w.vert_a_v, w.vert_c_v);
    au_d   = sub_c(w.point_u, w.vert_a_u);
    av_d   = sub_c(w.point_v, w.vert_a_v);
    bu_d   = sub_c(w.point_u, w.vert_b_u);
    bv_d   = sub_c(w.point_v, w.vert_b_v);
    nen0_d = (w.normal_part > NormHalf) || (w.normal_part < -NormHalf);
  end

  always_comb begin
    dra_d  = mul_s(eu_q, fv_q);
    drb_d  = mul_s(ev_q, fu_q);
    sa_d   = mul_s(eu_q, dv_q);
    sb_d   = mul_s(ev_q, du_q);
    ta_d   = mul_s(fu_q, dv_q);
    tb_d   = mul_s(fv_q, du_q);
    qau_d  = sq_u(au_q);
    qav_d  = sq_u(av_q);
    qbu_d  = sq_u(bu_q);
    qbv_d  = sq_u(bv_q);
    qcu_d  = sq_u(du_q);
    qcv_d  = sq_u(dv_q);
    m2_1_d = Marg2W'(m_q) * Marg2W'(m_q);
  end

  always_comb begin
    det_d = sum_t'(dra_q) - sum_t'(drb_q);
    s_d   = sum_t'(sa_q) - sum_t'(sb_q);
    t_d   = sum_t'(ta_q) - sum_t'(tb_q);
    da_d  = Dist2W'(qau_q) + Dist2W'(qav_q);
    db_d  = Dist2W'(qbu_q) + Dist2W'(qbv_q);
    dc_d  = Dist2W'(qcu_q) + Dist2W'(qcv_q);
  end

  always_comb begin
    st_d   = st_t'(s_q) + st_t'(t_q);
    snn_d  = !s_q[SumW-1];
    snp_d  = s_q[SumW-1] || (s_q == '0);
    tnn_d  = !t_q[SumW-1];
    tnp_d  = t_q[SumW-1] || (t_q == '0);
    vert_d = (da_q <= Dist2W'(m2_2_q)) || (db_q <= Dist2W'(m2_2_q)) ||
             (dc_q <= Dist2W'(m2_2_q));
  end

  // a negative determinant flips the signs of s and t and the bound
  always_comb begin
    if (!det3_q[SumW-1]) begin
      near4_d = (snn_q && tnn_q && (st_q <= st_t'(det3_q))) || vert_q;
    end else begin
      near4_d = (snp_q && tnp_q && (st_q >= st_t'(det3_q))) || vert_q;
    end
  end

  always_comb begin
    hit_d = near5_q || (nen5_q && (ea || eb || ec));
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      du_q   <= du_d;
      dv_q   <= dv_d;
      eu_q   <= eu_d;
      ev_q   <= ev_d;
      fu_q   <= fu_d;
      fv_q   <= fv_d;
      au_q   <= au_d;
      av_q   <= av_d;
      bu_q   <= bu_d;
      bv_q   <= bv_d;
      m_q    <= w.margin;
      nen0_q <= nen0_d;
    end
    if (en[1]) begin
      dra_q  <= dra_d;
      drb_q  <= drb_d;
      sa_q   <= sa_d;
      sb_q   <= sb_d;
      ta_q   <= ta_d;
      tb_q   <= tb_d;
      qau_q  <= qau_d;
      qav_q  <= qav_d;
      qbu_q  <= qbu_d;
      qbv_q  <= qbv_d;
      qcu_q  <= qcu_d;
      qcv_q  <= qcv_d;
      m2_1_q <= m2_1_d;
      nen1_q <= nen0_q;
    end
    if (en[2]) begin
      det_q  <= det_d;
      s_q    <= s_d;
      t_q    <= t_d;
      da_q   <= da_d;
      db_q   <= db_d;
      dc_q   <= dc_d;
      m2_2_q <= m2_1_q;
      nen2_q <= nen1_q;
    end
    if (en[3]) begin
      st_q   <= st_d;
      det3_q <= det_q;
      snn_q  <= snn_d;
      snp_q  <= snp_d;
      tnn_q  <= tnn_d;
      tnp_q  <= tnp_d;
      vert_q <= vert_d;
      m2_3_q <= m2_2_q;
      nen3_q <= nen2_q;
    end
    if (en[4]) begin
      near4_q <= near4_d;
      nen4_q  <= nen3_q;
    end
    if (en[5]) begin
      near5_q <= near4_q;
      nen5_q  <= nen4_q;
    end
    if (en[6]) begin
      hit_q <= hit_d;
    end
  end

  // edges a-b, b-c, c-a
  pitm_edge u_edge_ab (
    .clk_i     (clk_i),
    .en_i      (en[NumStages-2:0]),
    .point_u_i (w.point_u),
    .point_v_i (w.point_v),
    .x_u_i     (w.vert_a_u),
    .x_v_i     (w.vert_a_v),
    .y_u_i     (w.vert_b_u),
    .y_v_i     (w.vert_b_v),
    .m2_i      (m2_3_q),
    .near_o    (ea)
  );

  pitm_edge u_edge_bc (
    .clk_i     (clk_i),
    .en_i      (en[NumStages-2:0]),
    .point_u_i (w.point_u),
    .point_v_i (w.point_v),
    .x_u_i     (w.vert_b_u),
    .x_v_i     (w.vert_b_v),
    .y_u_i     (w.vert_c_u),
    .y_v_i     (w.vert_c_v),
    .m2_i      (m2_3_q),
    .near_o    (eb)
  );

  pitm_edge u_edge_ca (
    .clk_i     (clk_i),
    .en_i      (en[NumStages-2:0]),
    .point_u_i (w.point_u),
    .point_v_i (w.point_v),
    .x_u_i     (w.vert_c_u),
    .x_v_i     (w.vert_c_v),
    .y_u_i     (w.vert_a_u),
    .y_v_i     (w.vert_a_v),
    .m2_i      (m2_3_q),
    .near_o    (ec)
  );

  assign out_o.valid       = vld_q[NumStages-1];
  assign out_o.payload.hit = hit_q;

  `PITM_ASSERT_NXT(a_accept_fills_first, in_i.valid && in_i.ready, vld_q[0],
    "accepted word missing from first stage")

  `PITM_ASSERT_IMP(a_full_stall_blocks, (&vld_q) && !out_o.ready, !in_i.ready,
    "word taken while pipeline is full and stalled")

  for (genvar k = 0; k < NumStages - 1; k++) begin : g_chk
    `PITM_ASSERT_NXT(a_stall_holds, vld_q[k] && !en[k+1], vld_q[k],
      "stalled stage lost its word")
    `PITM_ASSERT_NXT(a_advance_moves, vld_q[k] && en[k+1], vld_q[k+1],
      "word lost between stages")
  end

endmodule

FILE: tb/tb_point_in_triangle_with_margin.sv
// testbench for the point-in-triangle test with margin: directed and random words, checked
module tb_point_in_triangle_with_margin
  import pitm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StuckLimit = 4000;
  localparam int TailCycles = NumStages + 4;

  typedef logic signed [127:0] wide_t;

  logic clk;
  logic rst_n;

  pitm_in_if  in_if ();
  pitm_out_if out_if ();

  point_in_triangle_with_margin u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic expected_hits[$];
  int   errors;
  int   stuck_cycles;
  logic want_hit;
  bit   src_idle_on;
  bit   sink_idle_on;
  bit   hold_req;
  int   hold_len;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hit predictor
  function automatic logic in_triangle(wide_t pu, wide_t pv, wide_t au, wide_t av,
                                       wide_t bu, wide_t bv, wide_t cu, wide_t cv);
    wide_t du, dv, eu, ev, fu, fv, det, s, t;
    du  = pu - cu;
    dv  = pv - cv;
    eu  = cu - bu;
    ev  = cv - bv;
    fu  = au - cu;
    fv  = av - cv;
    det = eu * fv - ev * fu;
    s   = eu * dv - ev * du;
    t   = fu * dv - fv * du;
    if (det < 0) begin
      s   = -s;
      t   = -t;
      det = -det;
    end
    return (s >= 0) && (t >= 0) && (s + t <= det);
  endfunction

  function automatic logic near_corner(wide_t pu, wide_t pv, wide_t qu, wide_t qv,
                                       wide_t mg);
    wide_t du, dv;
    du = pu - qu;
    dv = pv - qv;
    return du * du + dv * dv <= mg * mg;
  endfunction

  function automatic logic near_side(wide_t pu, wide_t pv, wide_t xu, wide_t xv,
                                     wide_t yu, wide_t yv, wide_t mg);
    wide_t gu, gv, hu, hv, len2, lam, r;
    gu   = yu - xu;
    gv   = yv - xv;
    hu   = pu - xu;
    hv   = pv - xv;
    len2 = gu * gu + gv * gv;
    lam  = hu * gu + hv * gv;
    r    = hu * gv - hv * gu;
    if (lam < 0 || lam > len2) return 1'b0;
    return r * r <= mg * mg * len2;
  endfunction

  function automatic logic predict_hit(in_word_t w);
    wide_t pu, pv, au, av, bu, bv, cu, cv, nrm, mg;
    logic  edges_on;
    pu  = w.point_u;
    pv  = w.point_v;
    au  = w.vert_a_u;
    av  = w.vert_a_v;
    bu  = w.vert_b_u;
    bv  = w.vert_b_v;
    cu  = w.vert_c_u;
    cv  = w.vert_c_v;
    nrm = w.normal_part;
    mg  = w.margin;
    if (nrm < 0) nrm = -nrm;
    edges_on = nrm > wide_t'(NormHalf);
    return in_triangle(pu, pv, au, av, bu, bv, cu, cv) ||
           near_corner(pu, pv, au, av, mg) ||
           near_corner(pu, pv, bu, bv, mg) ||
           near_corner(pu, pv, cu, cv, mg) ||
           (edges_on && (near_side(pu, pv, au, av, bu, bv, mg) ||
                         near_side(pu, pv, bu, bv, cu, cv, mg) ||
                         near_side(pu, pv, cu, cv, au, av, mg)));
  endfunction

  function automatic in_word_t query(int pu, int pv, int au, int av, int bu, int bv,
                                     int cu, int cv, int nrm, int mg);
    in_word_t w;
    w.point_u     = coord_t'(pu);
    w.point_v     = coord_t'(pv);
    w.vert_a_u    = coord_t'(au);
    w.vert_a_v    = coord_t'(av);
    w.vert_b_u    = coord_t'(bu);
    w.vert_b_v    = coord_t'(bv);
    w.vert_c_u    = coord_t'(cu);
    w.vert_c_v    = coord_t'(cv);
    w.normal_part = coord_t'(nrm);
    w.margin      = MarginW'(mg);
    return w;
  endfunction

  function automatic int jitter(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic in_word_t random_query();
    in_word_t w;
    int ctr_u, ctr_v, span, au, av, bu, bv, cu, cv, pu, pv, mg, pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      w = query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
      return w;
    end
    ctr_u = int'($urandom_range(0, 60000)) - 30000;
    ctr_v = int'($urandom_range(0, 60000)) - 30000;
    span  = 1 << $urandom_range(2, 12);
    au = jitter(ctr_u, span);
    av = jitter(ctr_v, span);
    bu = jitter(ctr_u, span);
    bv = jitter(ctr_v, span);
    if ($urandom_range(0, 15) == 0) begin
      cu = au;
      cv = av;
    end else begin
      cu = jitter(ctr_u, span);
      cv = jitter(ctr_v, span);
    end
    case ($urandom_range(0, 2))
      0: begin
        pu = jitter(ctr_u, 2 * span);
        pv = jitter(ctr_v, 2 * span);
      end
      1: begin
        pu = jitter(bu, span / 4);
        pv = jitter(bv, span / 4);
      end
      default: begin
        pu = jitter((au + cu) / 2, span / 4);
        pv = jitter((av + cv) / 2, span / 4);
      end
    endcase
    case ($urandom_range(0, 5))
      0:       mg = 0;
      1:       mg = $urandom_range(0, 32767);
      default: mg = $urandom_range(0, span / 2);
    endcase
    return query(pu, pv, au, av, bu, bv, cu, cv, $urandom, mg);
  endfunction

  task automatic send_query(input in_word_t w);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (!in_if.valid) in_if.valid <= 1'b1;
    in_if.payload <= w;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_hits.push_back(predict_hit(w));
  endtask

  initial begin : result_sink
    int gap;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (int k = 1; k < hold_len; k++) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual hit=%0b",
                 $time, out_if.payload.hit);
        errors++;
      end else begin
        want_hit = expected_hits.pop_front();
        if (out_if.payload.hit !== want_hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b",
                   $time, want_hit, out_if.payload.hit);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("tb_point_in_triangle_with_margin failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    // degenerate point triangle and full-scale corners
    send_query(query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_query(query(32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768,
                     -32768, 32767));
    send_query(query(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 32767, 0));
    // inside, both windings, and outside
    send_query(query(10, 10, 0, 0, 100, 0, 0, 100, 0, 0));
    send_query(query(10, 10, 0, 0, 0, 100, 100, 0, 0, 0));
    send_query(query(200, 200, 0, 0, 100, 0, 0, 100, 0, 0));
    // vertex distance on the bound and just outside it
    send_query(query(-3, -4, 0, 0, 100, 0, 0, 100, 0, 5));
    send_query(query(-3, -4, 0, 0, 100, 0, 0, 100, 0, 4));
    // edge margin around the half threshold of the normal, then beyond the margin and the edge end
    send_query(query(50, -3, 0, 0, 100, 0, 0, 100, 16385, 3));
    send_query(query(50, -3, 0, 0, 100, 0, 0, 100, 16384, 3));
    send_query(query(50, -3, 0, 0, 100, 0, 0, 100, -16384, 3));
    send_query(query(50, -3, 0, 0, 100, 0, 0, 100, -16385, 3));
    send_query(query(50, -3, 0, 0, 100, 0, 0, 100, -32768, 3));
    send_query(query(50, -4, 0, 0, 100, 0, 0, 100, 32767, 3));
    send_query(query(103, -3, 0, 0, 100, 0, 0, 100, 32767, 3));
    // coincident vertices give a zero-length edge
    send_query(query(-5000, 3000, 0, 0, 0, 0, 100, 100, 20000, 0));
    send_query(query(-5000, 3000, 0, 0, 0, 0, 100, 100, 0, 0));
    // collinear vertices, zero determinant
    send_query(query(25, 25, 0, 0, 50, 50, 100, 100, 0, 0));
    send_query(query(25, 26, 0, 0, 50, 50, 100, 100, 0, 0));
    // widest products
    send_query(query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    send_query(query(32767, -32768, -32768, -32768, 32767, 32767, -32768, 32767,
                     -32768, 32767));
    send_query(query(32767, -32768, -32768, -32768, 32767, 32767, -32768, 32767, 0, 32767));
  endtask

  task automatic test_random(int count);
    repeat (count) send_query(random_query());
  endtask

  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    hold_len     = 80;
    hold_req     = 1'b1;
    test_random(80);
    src_idle_on  = 1'b1;
  endtask

  task automatic test_streaming();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random(450);
  endtask

  initial begin
    errors        = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    hold_req      = 1'b0;
    hold_len      = 0;
    stuck_cycles  = 0;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(1000);
    test_backpressure();
    test_streaming();

    in_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_point_in_triangle_with_margin passed");
    end else begin
      $display("tb_point_in_triangle_with_margin failed");
    end
    $finish;
  end

endmodule

FILE: point_in_triangle_with_margin.f
+incdir+hw/rtl
hw/rtl/pitm_pkg.sv
hw/rtl/pitm_in_if.sv
hw/rtl/pitm_out_if.sv
hw/rtl/pitm_edge.sv
hw/rtl/point_in_triangle_with_margin.sv
tb/tb_point_in_triangle_with_margin.sv
